// ===== sv/bslpd_pkg.sv =====
// Shared codes and widths for the button short/long press detector.
// No dependencies; imported by button_short_long_press_detector_core.
package bslpd_pkg;

	localparam int unsigned ElapsedW = 16;
	localparam int unsigned HoldW    = 8;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned CfgIdxW  = 1;

	localparam logic [ElapsedW-1:0] ElapsedMax = '1;
	localparam logic [HoldW-1:0]    HoldMax    = '1;

	localparam logic [ElapsedW-1:0] DebounceReset = 16'd20;
	localparam logic [HoldW-1:0]    LimitReset    = 8'd50;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_LIMIT    = 1'd1;

	// phase codes
	localparam logic [1:0] PH_UP         = 2'd0;
	localparam logic [1:0] PH_DOWN       = 2'd1;
	localparam logic [1:0] PH_AWAIT_LONG = 2'd2;

	// pending event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	// reported kind
	localparam logic KIND_SHORT = 1'b0;
	localparam logic KIND_LONG  = 1'b1;

endpackage

// ===== sv/button_short_long_press_detector_core.sv =====
// Button short/long press detector: one tick per request, registered state update.
// Depends on bslpd_pkg.
//
// Each accepted request is one timer tick carrying the sampled button level. The
// whole state update (saturating tick counter, debounce compare, hold counter and
// the up/down/awaiting-long-release machine) happens in the cycle the request is
// accepted, so a new tick is taken every cycle unless stalled. A finished press
// report sits in an output register backed by one skid entry; input stalls only
// when both are full. Reports go out once the button is seen released while in the
// up phase: 0 for a short press, 1 for a long press. Configuration writes take effect next cycle.
module button_short_long_press_detector_core
	import bslpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                pressed,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                event_kind
);

	logic [ElapsedW-1:0] debounce_q;
	logic [HoldW-1:0]    limit_q;

	logic [1:0]          phase_q, phase_d;
	logic [ElapsedW-1:0] elapsed_q, elapsed_d, elapsed_inc;
	logic [HoldW-1:0]    hold_q, hold_d;
	logic [1:0]          pend_q, pend_d;

	logic emit;
	logic emit_kind;

	logic out_valid_q, out_kind_q;
	logic skid_valid_q, skid_kind_q;

	logic in_fire, pop, push;

	assign in_ready = !skid_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign pop      = out_valid_q && out_ready;
	assign push     = in_fire && emit;

	assign out_valid  = out_valid_q;
	assign event_kind = out_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DebounceReset;
			limit_q    <= LimitReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_LIMIT:    limit_q    <= cfg_data[HoldW-1:0];
				default:      ;
			endcase
		end
	end

	assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		phase_d   = phase_q;
		elapsed_d = elapsed_inc;
		hold_d    = hold_q;
		pend_d    = pend_q;
		emit      = 1'b0;
		emit_kind = (pend_q == EV_SHORT) ? KIND_SHORT : KIND_LONG;
		case (phase_q)
			PH_DOWN: begin
				if (elapsed_inc >= debounce_q) begin
					elapsed_d = '0;
					if (pressed) begin
						pend_d = EV_SHORT;
						// compare uses the count before this sample
						if (hold_q >= limit_q) begin
							phase_d = PH_AWAIT_LONG;
						end
						if (hold_q != HoldMax) begin
							hold_d = hold_q + 1'b1;
						end
					end else begin
						phase_d = PH_UP;
					end
				end
			end
			PH_AWAIT_LONG: begin
				if (!pressed) begin
					pend_d  = EV_LONG;
					phase_d = PH_UP;
				end
			end
			default: begin
				// unused code 3 behaves as up
				phase_d = PH_UP;
				if (pressed) begin
					pend_d    = EV_NONE;
					hold_d    = '0;
					phase_d   = PH_DOWN;
					elapsed_d = '0;
				end else if (pend_q != EV_NONE) begin
					emit   = 1'b1;
					pend_d = EV_NONE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_UP;
			elapsed_q <= '0;
			hold_q    <= '0;
			pend_q    <= EV_NONE;
		end else if (in_fire) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			hold_q    <= hold_d;
			pend_q    <= pend_d;
		end
	end

	// output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_kind_q <= skid_kind_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_kind_q <= emit_kind;
			end else begin
				skid_kind_q <= emit_kind;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready))
		else $error("skid entry filled without an output stall");

	a_long_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_AWAIT_LONG && !pressed)
		|=> (pend_q == EV_LONG && phase_q == PH_UP))
		else $error("release after long hold did not mark a long press");

endmodule
